>>> sv/ursi_pkg.sv
`default_nettype none

package ursi_pkg;

  // Item kinds.
  localparam logic [2:0] FUNC_READ  = 3'd0;
  localparam logic [2:0] FUNC_WRITE = 3'd1;
  localparam logic [2:0] FUNC_RXB   = 3'd2;
  localparam logic [2:0] FUNC_BREAK = 3'd3;
  localparam logic [2:0] FUNC_TICK  = 3'd4;

  // Register offsets.
  localparam logic [2:0] ADDR_MODE   = 3'd0;
  localparam logic [2:0] ADDR_BAUD   = 3'd1;
  localparam logic [2:0] ADDR_CTRL   = 3'd2;
  localparam logic [2:0] ADDR_TDR    = 3'd3;
  localparam logic [2:0] ADDR_STATUS = 3'd4;
  localparam logic [2:0] ADDR_RDR    = 3'd5;
  localparam logic [2:0] ADDR_SMART  = 3'd6;
  localparam logic [2:0] ADDR_EXT    = 3'd7;

  // Status bits.
  localparam logic [7:0] ST_TDRE = 8'h80;
  localparam logic [7:0] ST_RDRF = 8'h40;
  localparam logic [7:0] ST_ORER = 8'h20;
  localparam logic [7:0] ST_FER  = 8'h10;
  localparam logic [7:0] ST_ERR  = 8'h38;
  localparam logic [7:0] ST_TEND = 8'h04;
  localparam logic [7:0] ST_MPBT = 8'h01;

  // Control bits.
  localparam logic [7:0] CR_TIE  = 8'h80;
  localparam logic [7:0] CR_RIE  = 8'h40;
  localparam logic [7:0] CR_TE   = 8'h20;
  localparam logic [7:0] CR_RE   = 8'h10;
  localparam logic [7:0] CR_TEIE = 8'h04;

  // Reset values.
  localparam logic [7:0] BAUD_RST   = 8'hFF;
  localparam logic [7:0] TDR_RST    = 8'hFF;
  localparam logic [7:0] STATUS_RST = 8'h84;
  localparam logic [7:0] IDLE_READ  = 8'hFF;

  // Longest character time is 11 * 32 * 255 * 64, which fits in 23 bits.
  localparam int unsigned CHAR_TIME_W = 23;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_ready;
    logic       rx_int_pulse;
    logic       tx_int_pulse;
    logic       err_int_level;
    logic       tend_int_level;
  } result_t;

  // Ticks per character: bits * 32 * baud * 4^CKS.
  function automatic logic [CHAR_TIME_W-1:0] char_time(input logic [7:0] mode,
                                                       input logic [7:0] baud);
    logic [3:0]  bits;
    logic [11:0] prod;
    bits = 4'(4'd9 - {3'b000, mode[6]} + {3'b000, mode[5]} + {3'b000, mode[3]});
    prod = 12'({8'h00, bits} * {4'h0, baud});
    return {6'b000000, prod, 5'b00000} << {mode[1:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

>>> sv/ursi_if.sv
`default_nettype none

interface ursi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [2:0] reg_addr;
  logic [7:0] write_data;
  logic [7:0] rx_byte;

  modport source (output valid, func, reg_addr, write_data, rx_byte, input ready);
  modport sink   (input valid, func, reg_addr, write_data, rx_byte, output ready);
endinterface

interface ursi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       rx_ready;
  logic       rx_int_pulse;
  logic       tx_int_pulse;
  logic       err_int_level;
  logic       tend_int_level;

  modport source (output valid, read_data, tx_valid, tx_byte, rx_ready, rx_int_pulse,
                  tx_int_pulse, err_int_level, tend_int_level, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, rx_ready, rx_int_pulse,
                  tx_int_pulse, err_int_level, tend_int_level, output ready);
endinterface

`default_nettype wire

>>> sv/ursi_in_stage.sv
`default_nettype none

// Input register: holds one item until the core takes it.
module ursi_in_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire ursi_pkg::item_t item_i,
  output logic                valid_o,
  input  wire logic           take_i,
  output ursi_pkg::item_t     item_o
);

  logic            valid_q;
  ursi_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/ursi_core.sv
`default_nettype none

// Register file, character timers and the result register.
module ursi_core #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire ursi_pkg::item_t  item_i,
  output logic                  take_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output ursi_pkg::result_t     result_o
);

  logic [7:0] mode_q, mode_d, baud_q, baud_d, ctrl_q, ctrl_d, tdr_q, tdr_d;
  logic [7:0] status_q, status_d, rdr_q, rdr_d, smart_q, smart_d, ext_q, ext_d;
  logic [7:0] snap_q, snap_d;
  logic [TIMER_WIDTH-1:0] tx_cnt_q, tx_cnt_d, rx_cnt_q, rx_cnt_d;
  logic tx_act_q, tx_act_d, err_q, err_d, tend_q, tend_d;
  logic out_valid_q;
  ursi_pkg::result_t res_q, res_d;

  logic [TIMER_WIDTH-1:0] ctime;
  logic enabled, send;

  assign take_o      = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  assign ctime   = TIMER_WIDTH'(ursi_pkg::char_time(mode_q, baud_q));
  assign enabled = (ctrl_q & (ursi_pkg::CR_TE | ursi_pkg::CR_RE)) != 8'h00;

  always_comb begin
    mode_d = mode_q;   baud_d = baud_q;     ctrl_d = ctrl_q;   tdr_d = tdr_q;
    status_d = status_q; rdr_d = rdr_q;     smart_d = smart_q; ext_d = ext_q;
    snap_d = snap_q;   tx_cnt_d = tx_cnt_q; rx_cnt_d = rx_cnt_q;
    tx_act_d = tx_act_q; err_d = err_q;     tend_d = tend_q;
    send = 1'b0;
    res_d = '0;
    res_d.read_data = ursi_pkg::IDLE_READ;

    unique case (item_i.func)
      ursi_pkg::FUNC_READ: begin
        unique case (item_i.reg_addr)
          ursi_pkg::ADDR_MODE:   res_d.read_data = mode_q;
          ursi_pkg::ADDR_BAUD:   res_d.read_data = baud_q;
          ursi_pkg::ADDR_CTRL:   res_d.read_data = ctrl_q;
          ursi_pkg::ADDR_TDR:    res_d.read_data = tdr_q;
          ursi_pkg::ADDR_STATUS: begin
            snap_d = status_q;
            res_d.read_data = status_q;
          end
          ursi_pkg::ADDR_RDR: begin
            status_d = status_q & ~ursi_pkg::ST_RDRF;
            res_d.read_data = rdr_q;
          end
          ursi_pkg::ADDR_SMART:  res_d.read_data = smart_q;
          default:               res_d.read_data = ext_q;
        endcase
      end
      ursi_pkg::FUNC_WRITE: begin
        unique case (item_i.reg_addr)
          ursi_pkg::ADDR_MODE: if (!enabled) mode_d = item_i.write_data;
          ursi_pkg::ADDR_BAUD: if (!enabled) baud_d = item_i.write_data;
          ursi_pkg::ADDR_CTRL: begin
            ctrl_d = item_i.write_data;
            if ((item_i.write_data & ursi_pkg::CR_TE) != 8'h00) begin
              status_d = status_q | ursi_pkg::ST_TDRE | ursi_pkg::ST_TEND;
              if ((item_i.write_data & ursi_pkg::CR_TIE) != 8'h00) res_d.tx_int_pulse = 1'b1;
            end
            if ((item_i.write_data & ursi_pkg::CR_TEIE) == 8'h00) tend_d = 1'b0;
            if ((item_i.write_data & ursi_pkg::CR_RIE) == 8'h00) err_d = 1'b0;
          end
          ursi_pkg::ADDR_TDR: begin
            tdr_d = item_i.write_data;
            if ((status_q & ursi_pkg::ST_TEND) != 8'h00) begin
              send = 1'b1;
            end else begin
              status_d = status_q & ~ursi_pkg::ST_TDRE;
            end
          end
          ursi_pkg::ADDR_STATUS: begin
            status_d = (status_q & ~(ursi_pkg::ST_MPBT | ursi_pkg::ST_ERR))
                     | (item_i.write_data & (ursi_pkg::ST_MPBT | ursi_pkg::ST_ERR));
            if ((snap_q & ursi_pkg::ST_ERR) != 8'h00 &&
                (item_i.write_data & ursi_pkg::ST_ERR) == 8'h00) begin
              err_d = 1'b0;
            end
          end
          ursi_pkg::ADDR_RDR:   ;
          ursi_pkg::ADDR_SMART: smart_d = item_i.write_data;
          default:              ext_d = item_i.write_data;
        endcase
      end
      ursi_pkg::FUNC_RXB: begin
        rx_cnt_d = ctime;
        if ((status_q & ursi_pkg::ST_RDRF) != 8'h00) begin
          status_d = status_q | ursi_pkg::ST_ORER;
          if ((ctrl_q & ursi_pkg::CR_RIE) != 8'h00) err_d = 1'b1;
        end else begin
          rdr_d = item_i.rx_byte;
          status_d = status_q | ursi_pkg::ST_RDRF;
          if ((ctrl_q & ursi_pkg::CR_RIE) != 8'h00) res_d.rx_int_pulse = 1'b1;
        end
      end
      ursi_pkg::FUNC_BREAK: begin
        status_d = status_q | ursi_pkg::ST_FER;
        if ((ctrl_q & ursi_pkg::CR_RIE) != 8'h00) err_d = 1'b1;
      end
      ursi_pkg::FUNC_TICK: begin
        if (rx_cnt_q != '0) rx_cnt_d = rx_cnt_q - TIMER_WIDTH'(1);
        if (tx_act_q) begin
          if (tx_cnt_q <= TIMER_WIDTH'(1)) begin
            tx_act_d = 1'b0;
            tx_cnt_d = '0;
            if ((status_q & ursi_pkg::ST_TDRE) == 8'h00) begin
              send = 1'b1;
            end else begin
              status_d = status_q | ursi_pkg::ST_TEND;
              if ((ctrl_q & ursi_pkg::CR_TEIE) != 8'h00) tend_d = 1'b1;
            end
          end else begin
            tx_cnt_d = tx_cnt_q - TIMER_WIDTH'(1);
          end
        end
      end
      default: ;
    endcase

    // A byte leaves the transmit data register and the timer reloads.
    if (send) begin
      res_d.tx_valid = 1'b1;
      res_d.tx_byte  = tdr_d;
      tx_cnt_d = ctime;
      tx_act_d = 1'b1;
      status_d = (status_d & ~ursi_pkg::ST_TEND) | ursi_pkg::ST_TDRE;
      tend_d   = 1'b0;
      if ((ctrl_q & ursi_pkg::CR_TIE) != 8'h00) res_d.tx_int_pulse = 1'b1;
    end

    res_d.rx_ready       = ((ctrl_d & ursi_pkg::CR_RE) != 8'h00) && (rx_cnt_d == '0);
    res_d.err_int_level  = err_d;
    res_d.tend_int_level = tend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 8'h00;
      baud_q   <= ursi_pkg::BAUD_RST;
      ctrl_q   <= 8'h00;
      tdr_q    <= ursi_pkg::TDR_RST;
      status_q <= ursi_pkg::STATUS_RST;
      rdr_q    <= 8'h00;
      smart_q  <= 8'h00;
      ext_q    <= 8'h00;
      snap_q   <= 8'h00;
      tx_cnt_q <= '0;
      rx_cnt_q <= '0;
      tx_act_q <= 1'b0;
      err_q    <= 1'b0;
      tend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        mode_q   <= mode_d;
        baud_q   <= baud_d;
        ctrl_q   <= ctrl_d;
        tdr_q    <= tdr_d;
        status_q <= status_d;
        rdr_q    <= rdr_d;
        smart_q  <= smart_d;
        ext_q    <= ext_d;
        snap_q   <= snap_d;
        tx_cnt_q <= tx_cnt_d;
        rx_cnt_q <= rx_cnt_d;
        tx_act_q <= tx_act_d;
        err_q    <= err_d;
        tend_q   <= tend_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_send_starts_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && res_d.tx_valid |=> tx_act_q && status_q[7] && !status_q[2])
    else $error("transmit did not start the character timer");

  a_mode_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enabled |=> $stable(mode_q) && $stable(baud_q))
    else $error("mode or baud changed while the port was enabled");

  a_rx_pulse_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && res_d.rx_int_pulse |=> status_q[6] && out_valid_q)
    else $error("receive interrupt without receive data full");
`endif

endmodule

`default_nettype wire

>>> sv/uart_serial_interface_registers_top.sv
// Two registers (input, result); an item passes the input register, then the result register.
// Throughput: one item per cycle while the output is ready; one pass of flag and counter logic.
// While a result waits, the input register still takes one more item; then the input stalls.
// Reset (rst_ni low, asynchronous) restores the register file to its documented values,
// stops both character timers and empties both pipeline registers.
`default_nettype none

module uart_serial_interface_registers_top #(
  parameter int unsigned TIMER_WIDTH = 24
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ursi_in_if.sink   in_i,
  ursi_out_if.source out_o
);

  // Item handed from the input register to the core.
  ursi_pkg::item_t   in_item, stage_item;
  ursi_pkg::result_t result;
  logic              stage_valid;
  logic              take;

  assign in_item.func       = in_i.func;
  assign in_item.reg_addr   = in_i.reg_addr;
  assign in_item.write_data = in_i.write_data;
  assign in_item.rx_byte    = in_i.rx_byte;

  // The input register frees itself whenever the core takes its item.
  ursi_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (take),
    .item_o  (stage_item)
  );

  // The core updates the register state and loads the result register in the same cycle.
  ursi_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .item_i      (stage_item),
    .take_o      (take),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.read_data      = result.read_data;
  assign out_o.tx_valid       = result.tx_valid;
  assign out_o.tx_byte        = result.tx_byte;
  assign out_o.rx_ready       = result.rx_ready;
  assign out_o.rx_int_pulse   = result.rx_int_pulse;
  assign out_o.tx_int_pulse   = result.tx_int_pulse;
  assign out_o.err_int_level  = result.err_int_level;
  assign out_o.tend_int_level = result.tend_int_level;

endmodule

`default_nettype wire
